// ----- src/tpdc_pkg.sv -----
// Shared types, constants and the cosine function for the tilt PD torque controller.
// Used by every module of the block but the checker; depends on nothing else.
package tpdc_pkg;

	localparam int COS_TABLE_DEPTH_DEF = 256;

	localparam int TURN_UNITS      = 23040;
	localparam int HALF_TURN_UNITS = 11520;

	localparam longint Q28_ONE     = 64'sd268435456;
	localparam longint Q28_TWO_PI  = 64'sd1686629713;
	localparam longint Q28_PI      = 64'sd843314857;
	localparam longint Q28_HALF_PI = 64'sd421657428;

	// Configuration register file.
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int DATA_W    = 32;

	localparam logic [REG_IDX_W-1:0] REG_SETPOINT_ANGLE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SETPOINT_LEVEL = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TORQUE_BASE    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TORQUE_GAIN    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LATERAL_GAIN   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_TORQUE_LIMIT   = 3'd7;

	localparam logic [14:0]        RST_SETPOINT_ANGLE = 15'd11808;
	localparam logic signed [15:0] RST_SETPOINT_LEVEL = 16'sd16384;
	localparam logic [15:0]        RST_PROP_GAIN      = 16'd5124;
	localparam logic [15:0]        RST_DERIV_GAIN     = 16'd1546;
	localparam logic [9:0]         RST_TORQUE_BASE    = 10'd200;
	localparam logic [15:0]        RST_TORQUE_GAIN    = 16'd1745;
	localparam logic [15:0]        RST_LATERAL_GAIN   = 16'd3277;
	localparam logic [9:0]         RST_TORQUE_LIMIT   = 10'd1023;

	// Shared multiply-accumulate unit.
	localparam int MAC_W        = 20;
	localparam int ACC_W        = 56;
	localparam int MAC_HI_SHIFT = 18;

	// Division by the turn length: a shift by 9, then by 45 through a reciprocal.
	localparam int          DIV_PRE_SHIFT = 9;
	localparam int          DIV_CONST     = 45;
	localparam int          RECIP_SHIFT   = 23;
	localparam logic [17:0] RECIP_45      = 18'd186413;

	typedef struct packed {
		logic [14:0]        setpoint_angle;
		logic signed [15:0] setpoint_level;
		logic [15:0]        prop_gain;
		logic [15:0]        deriv_gain;
		logic [9:0]         torque_base;
		logic [15:0]        torque_gain;
		logic [15:0]        lateral_gain;
		logic [9:0]         torque_limit;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic accum;
		logic shift_hi;
	} mac_ctrl_t;

	// Cosine in Q2.14 of a Q4.28 phase in [0, pi]; evaluated at elaboration only.
	function automatic logic signed [15:0] cos_q14_theta(input longint theta_in);
		longint theta;
		longint x2;
		longint t;
		logic   neg;
		theta = theta_in;
		neg   = 1'b0;
		if (theta > Q28_HALF_PI) begin
			theta = Q28_PI - theta;
			neg   = 1'b1;
		end
		if (theta < 0)
			theta = 0;
		x2 = (theta * theta) >>> 28;
		t  = Q28_ONE - x2 / 90;
		t  = Q28_ONE - ((x2 * t) >>> 28) / 56;
		if (t < 0)
			t = 0;
		t = Q28_ONE - ((x2 * t) >>> 28) / 30;
		if (t < 0)
			t = 0;
		t = Q28_ONE - ((x2 * t) >>> 28) / 12;
		if (t < 0)
			t = 0;
		t = Q28_ONE - ((x2 * t) >>> 28) / 2;
		if (t < 0)
			t = 0;
		t = (t + 8192) >>> 14;
		return neg ? 16'(-t) : 16'(t);
	endfunction

endpackage

// ----- src/tpdc_regs.sv -----
// APB-style configuration register file of the tilt PD torque controller.
// Depends on tpdc_pkg for the register indexes, reset values and cfg_t.
module tpdc_regs import tpdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_angle <= RST_SETPOINT_ANGLE;
			cfg_q.setpoint_level <= RST_SETPOINT_LEVEL;
			cfg_q.prop_gain      <= RST_PROP_GAIN;
			cfg_q.deriv_gain     <= RST_DERIV_GAIN;
			cfg_q.torque_base    <= RST_TORQUE_BASE;
			cfg_q.torque_gain    <= RST_TORQUE_GAIN;
			cfg_q.lateral_gain   <= RST_LATERAL_GAIN;
			cfg_q.torque_limit   <= RST_TORQUE_LIMIT;
		end else if (wr_en) begin
			case (idx)
				REG_SETPOINT_ANGLE: cfg_q.setpoint_angle <= pwdata[14:0];
				REG_SETPOINT_LEVEL: cfg_q.setpoint_level <= $signed(pwdata[15:0]);
				REG_PROP_GAIN:      cfg_q.prop_gain      <= pwdata[15:0];
				REG_DERIV_GAIN:     cfg_q.deriv_gain     <= pwdata[15:0];
				REG_TORQUE_BASE:    cfg_q.torque_base    <= pwdata[9:0];
				REG_TORQUE_GAIN:    cfg_q.torque_gain    <= pwdata[15:0];
				REG_LATERAL_GAIN:   cfg_q.lateral_gain   <= pwdata[15:0];
				REG_TORQUE_LIMIT:   cfg_q.torque_limit   <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SETPOINT_ANGLE: prdata = DATA_W'(cfg_q.setpoint_angle);
			REG_SETPOINT_LEVEL: prdata = DATA_W'(unsigned'(cfg_q.setpoint_level));
			REG_PROP_GAIN:      prdata = DATA_W'(cfg_q.prop_gain);
			REG_DERIV_GAIN:     prdata = DATA_W'(cfg_q.deriv_gain);
			REG_TORQUE_BASE:    prdata = DATA_W'(cfg_q.torque_base);
			REG_TORQUE_GAIN:    prdata = DATA_W'(cfg_q.torque_gain);
			REG_LATERAL_GAIN:   prdata = DATA_W'(cfg_q.lateral_gain);
			REG_TORQUE_LIMIT:   prdata = DATA_W'(cfg_q.torque_limit);
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- src/tpdc_mac.sv -----
// Shared signed multiply-accumulate unit of the tilt PD torque controller.
// Depends on tpdc_pkg for the operand widths and mac_ctrl_t.
module tpdc_mac import tpdc_pkg::*; (
	input  logic                    clk,
	input  mac_ctrl_t               ctrl,
	input  logic signed [MAC_W-1:0] op_a,
	input  logic signed [MAC_W-1:0] op_b,
	input  logic signed [ACC_W-1:0] addend,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [2*MAC_W-1:0] prod;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   term;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   acc_q;

	assign prod     = op_a * op_b;
	assign prod_ext = ACC_W'(prod);
	assign term     = ctrl.shift_hi ? (prod_ext <<< MAC_HI_SHIFT) : prod_ext;
	assign base     = ctrl.accum ? acc_q : addend;
	assign acc      = acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.en)
			acc_q <= base + term;
	end

endmodule

// ----- src/tpdc_cos_rom.sv -----
// Cosine ROM over the first half turn, Q2.14, built at elaboration with a registered read.
// Depends on tpdc_pkg for the phase constants and the cosine function.
module tpdc_cos_rom import tpdc_pkg::*; #(
	parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF,
	localparam int ROM_DEPTH = COS_TABLE_DEPTH / 2 + 1,
	localparam int ROM_AW    = $clog2(ROM_DEPTH)
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [ROM_AW-1:0]        addr,
	output logic signed [15:0]       data
);

	logic signed [15:0] rom_w [ROM_DEPTH];
	logic signed [15:0] data_q;

	for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
		localparam longint THETA = (longint'(i) * Q28_TWO_PI) / COS_TABLE_DEPTH;
		assign rom_w[i] = cos_q14_theta(THETA);
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			data_q <= rom_w[addr];
	end

	assign data = data_q;

endmodule

// ----- src/tilt_pd_torque_controller_unit.sv -----
// Tilt PD torque controller: one result beat of torque and lateral offset per tilt sample.
// Each sample takes a wrap step, eight passes through the one shared multiply-accumulate
// unit, a cosine ROM read and the level subtraction, then the output commit, which waits
// while an earlier result is still held and not taken. No new sample is taken until the
// commit. A finished result waits in its register while the next sample is taken.
// Reset loads the register defaults, clears the previous level and empties the output.
module tilt_pd_torque_controller_unit import tpdc_pkg::*; #(
	parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [14:0]        tilt_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         torque,
	output logic signed [15:0] lateral_offset,
	output logic               saturated
);

	localparam int N_MAX     = HALF_TURN_UNITS * COS_TABLE_DEPTH + HALF_TURN_UNITS;
	localparam int N_W       = $clog2(N_MAX + 1);
	localparam int M_W       = N_W - DIV_PRE_SHIFT;
	localparam int QR_W      = $clog2(COS_TABLE_DEPTH + 1);
	localparam int ROM_DEPTH = COS_TABLE_DEPTH / 2 + 1;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);
	localparam int TR_W      = ACC_W - 30;

	localparam logic signed [ACC_W-1:0] TQ_ROUND  = ACC_W'(64'sd1 <<< 29);
	localparam logic signed [ACC_W-1:0] OFF_ROUND = ACC_W'(64'sd1 <<< 15);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_WRAP   = 4'd1;
	localparam logic [3:0] ST_NUM    = 4'd2;
	localparam logic [3:0] ST_RECIP  = 4'd3;
	localparam logic [3:0] ST_CHECK  = 4'd4;
	localparam logic [3:0] ST_FOLD   = 4'd5;
	localparam logic [3:0] ST_LEVEL  = 4'd6;
	localparam logic [3:0] ST_PROP   = 4'd7;
	localparam logic [3:0] ST_DERIV  = 4'd8;
	localparam logic [3:0] ST_TLO    = 4'd9;
	localparam logic [3:0] ST_THI    = 4'd10;
	localparam logic [3:0] ST_LAT    = 4'd11;
	localparam logic [3:0] ST_OUT    = 4'd12;

	cfg_t cfg;

	logic [3:0]               state_q;
	logic [14:0]              tilt_q;
	logic signed [14:0]       err_q;
	logic [M_W-1:0]           m_q;
	logic [QR_W-1:0]          q0_q;
	logic signed [17:0]       level_q;
	logic signed [17:0]       prev_q;
	logic signed [18:0]       pdhi_q;
	logic [TR_W-1:0]          tround_q;
	logic                     out_valid_q;
	logic [9:0]               torque_q;
	logic signed [15:0]       lateral_q;
	logic                     sat_q;

	mac_ctrl_t                mac_ctrl;
	logic signed [MAC_W-1:0]  op_a;
	logic signed [MAC_W-1:0]  op_b;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc;

	logic                     rom_rd;
	logic [ROM_AW-1:0]        rom_addr;
	logic signed [15:0]       cos_val;

	logic signed [16:0]       diff_w;
	logic signed [16:0]       wrap_w;
	logic [13:0]              mag_w;
	logic [M_W-1:0]           m_w;
	logic [QR_W-1:0]          q0_w;
	logic signed [M_W+1:0]    rem_w;
	logic [QR_W-1:0]          q_w;
	logic [QR_W-1:0]          qf_w;
	logic signed [18:0]       dlevel_w;
	logic [16:0]              lmag_w;
	logic [ACC_W-1:0]         tmag_w;
	logic [ACC_W-1:0]         tsum_w;
	logic [16:0]              omag_w;
	logic                     off_neg_w;
	logic                     commit;

	tpdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpdc_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.op_a   (op_a),
		.op_b   (op_b),
		.addend (addend),
		.acc    (acc)
	);

	tpdc_cos_rom #(
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH)
	) u_rom (
		.clk   (clk),
		.rd_en (rom_rd),
		.addr  (rom_addr),
		.data  (cos_val)
	);

	// Angle error wrapped into [-half turn, half turn).
	always_comb begin
		diff_w = $signed({2'b00, cfg.setpoint_angle}) - $signed({2'b00, tilt_q});
		if (diff_w >= 17'(HALF_TURN_UNITS))
			wrap_w = diff_w - 17'(TURN_UNITS);
		else if (diff_w < -17'(HALF_TURN_UNITS))
			wrap_w = diff_w + 17'(TURN_UNITS);
		else
			wrap_w = diff_w;
	end

	assign mag_w = err_q[14] ? 14'(-err_q) : 14'(err_q);
	assign m_w   = acc[DIV_PRE_SHIFT +: M_W];
	assign q0_w  = acc[RECIP_SHIFT +: QR_W];

	// The reciprocal quotient is at most one low; the remainder check puts it right.
	always_comb begin
		rem_w = $signed({2'b00, m_q}) - $signed((M_W+2)'(acc));
		q_w   = (rem_w >= (M_W+2)'(DIV_CONST)) ? q0_q + 1'b1 : q0_q;
		if ((QR_W+1)'(q_w) << 1 > (QR_W+1)'(COS_TABLE_DEPTH))
			qf_w = QR_W'(COS_TABLE_DEPTH) - q_w;
		else
			qf_w = q_w;
	end

	assign rom_rd   = (state_q == ST_FOLD);
	assign rom_addr = qf_w[ROM_AW-1:0];

	assign dlevel_w = 19'(level_q) - 19'(prev_q);
	assign lmag_w   = level_q[17] ? 17'(-level_q) : 17'(level_q);
	assign tmag_w   = acc[ACC_W-1] ? unsigned'(-acc) : unsigned'(acc);
	assign tsum_w   = tmag_w + unsigned'(TQ_ROUND);
	assign omag_w   = acc[16 +: 17];
	assign off_neg_w = (level_q > 18'sd0) ^ err_q[14];
	assign commit   = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Operand selection for the shared multiply-accumulate unit.
	always_comb begin
		mac_ctrl = '0;
		op_a     = '0;
		op_b     = '0;
		addend   = '0;
		case (state_q)
			ST_NUM: begin
				mac_ctrl.en = 1'b1;
				op_a        = MAC_W'(mag_w);
				op_b        = MAC_W'(COS_TABLE_DEPTH);
				addend      = ACC_W'(HALF_TURN_UNITS);
			end
			ST_RECIP: begin
				mac_ctrl.en = 1'b1;
				op_a        = MAC_W'(m_w);
				op_b        = MAC_W'(RECIP_45);
			end
			ST_CHECK: begin
				mac_ctrl.en = 1'b1;
				op_a        = MAC_W'(q0_w);
				op_b        = MAC_W'(DIV_CONST);
			end
			ST_PROP: begin
				mac_ctrl.en = 1'b1;
				op_a        = MAC_W'(cfg.prop_gain);
				op_b        = MAC_W'(level_q);
			end
			ST_DERIV: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.accum = 1'b1;
				op_a           = MAC_W'(cfg.deriv_gain);
				op_b           = MAC_W'(dlevel_w);
			end
			ST_TLO: begin
				mac_ctrl.en = 1'b1;
				op_a        = MAC_W'(acc[MAC_HI_SHIFT-1:0]);
				op_b        = MAC_W'(cfg.torque_gain);
				addend      = ACC_W'(cfg.torque_base) << 30;
			end
			ST_THI: begin
				mac_ctrl.en       = 1'b1;
				mac_ctrl.accum    = 1'b1;
				mac_ctrl.shift_hi = 1'b1;
				op_a              = MAC_W'(pdhi_q);
				op_b              = MAC_W'(cfg.torque_gain);
			end
			ST_LAT: begin
				mac_ctrl.en = 1'b1;
				op_a        = MAC_W'(lmag_w);
				op_b        = MAC_W'(cfg.lateral_gain);
				addend      = OFF_ROUND;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !commit)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_WRAP;
				ST_WRAP:  state_q <= ST_NUM;
				ST_NUM:   state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_FOLD;
				ST_FOLD:  state_q <= ST_LEVEL;
				ST_LEVEL: state_q <= ST_PROP;
				ST_PROP:  state_q <= ST_DERIV;
				ST_DERIV: state_q <= ST_TLO;
				ST_TLO:   state_q <= ST_THI;
				ST_THI:   state_q <= ST_LAT;
				ST_LAT:   state_q <= ST_OUT;
				ST_OUT: begin
					if (commit) begin
						state_q     <= ST_IDLE;
						prev_q      <= level_q;
						out_valid_q <= 1'b1;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			tilt_q <= tilt_sample;
		if (state_q == ST_WRAP)
			err_q <= 15'(wrap_w);
		if (state_q == ST_RECIP)
			m_q <= m_w;
		if (state_q == ST_CHECK)
			q0_q <= q0_w;
		if (state_q == ST_LEVEL)
			level_q <= 18'(cfg.setpoint_level) - 18'(cos_val);
		if (state_q == ST_TLO)
			pdhi_q <= acc[MAC_HI_SHIFT +: 19];
		if (state_q == ST_LAT)
			tround_q <= tsum_w[ACC_W-1:30];
		if (commit) begin
			if (tround_q > TR_W'(cfg.torque_limit)) begin
				torque_q <= cfg.torque_limit;
			end else begin
				torque_q <= tround_q[9:0];
			end
			if (off_neg_w) begin
				if (omag_w > 17'd32768)
					lateral_q <= 16'sh8000;
				else
					lateral_q <= 16'(-$signed({1'b0, omag_w}));
			end else begin
				if (omag_w > 17'd32767)
					lateral_q <= 16'sh7fff;
				else
					lateral_q <= 16'(omag_w);
			end
			sat_q <= (tround_q > TR_W'(cfg.torque_limit)) ||
			         (off_neg_w && omag_w > 17'd32768) ||
			         (!off_neg_w && omag_w > 17'd32767);
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign torque         = torque_q;
	assign lateral_offset = lateral_q;
	assign saturated      = sat_q;

endmodule

// ----- src/tpdc_checker.sv -----
// Port-level checks for the tilt PD torque controller, bound to its top level.
// Does not depend on tpdc_pkg; it sees only the ports of the bound module.
module tpdc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [9:0]         torque,
	input logic signed [15:0] lateral_offset,
	input logic               saturated
);

	// A sample keeps the block busy for the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a sample beat");

	// A new result is committed at the same edge the sequencer returns to idle.
	a_result_with_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while the sequencer was still busy");

	// While idle nothing is committed, so a taken result empties the output.
	a_no_phantom_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && in_ready) |=> !out_valid)
		else $error("result beat repeated or invented while idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(torque) &&
			$stable(lateral_offset) && $stable(saturated)))
		else $error("stalled result beat changed");

endmodule

bind tilt_pd_torque_controller_unit tpdc_checker u_tpdc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.torque         (torque),
	.lateral_offset (lateral_offset),
	.saturated      (saturated)
);

// ----- dv/tilt_pd_torque_controller_unit_tb.sv -----
// Self-checking testbench for the tilt PD torque controller: APB register setup and
// readback, directed and random tilt samples, and a per-beat check of every result.
// Depends on tpdc_pkg and tilt_pd_torque_controller_unit.
module tilt_pd_torque_controller_unit_tb;
	import tpdc_pkg::*;

	localparam int COS_DEPTH = COS_TABLE_DEPTH_DEF;

	typedef struct packed {
		logic [9:0]         torque;
		logic signed [15:0] lateral_offset;
		logic               saturated;
	} out_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [14:0]        tilt_sample = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [9:0]         torque;
	logic signed [15:0] lateral_offset;
	logic               saturated;

	cfg_t               ctrl_cfg;
	logic signed [17:0] last_level;
	out_beat_t          expected_beats[$];
	int                 fail_count = 0;
	bit                 sender_idles = 1'b1;
	bit                 receiver_idles = 1'b1;
	int                 ready_burst = 0;
	logic [14:0]        last_tilt = '0;

	tilt_pd_torque_controller_unit #(
		.COS_TABLE_DEPTH(COS_DEPTH)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.tilt_sample   (tilt_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.torque        (torque),
		.lateral_offset(lateral_offset),
		.saturated     (saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	function automatic cfg_t default_settings();
		cfg_t s;
		s.setpoint_angle = RST_SETPOINT_ANGLE;
		s.setpoint_level = RST_SETPOINT_LEVEL;
		s.prop_gain      = RST_PROP_GAIN;
		s.deriv_gain     = RST_DERIV_GAIN;
		s.torque_base    = RST_TORQUE_BASE;
		s.torque_gain    = RST_TORQUE_GAIN;
		s.lateral_gain   = RST_LATERAL_GAIN;
		s.torque_limit   = RST_TORQUE_LIMIT;
		return s;
	endfunction

	function automatic int reg_width(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_SETPOINT_ANGLE: return 15;
			REG_TORQUE_BASE, REG_TORQUE_LIMIT: return 10;
			default: return 16;
		endcase
	endfunction

	function automatic logic [31:0] field_of(input cfg_t s, input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_SETPOINT_ANGLE: return {17'd0, s.setpoint_angle};
			REG_SETPOINT_LEVEL: return {16'd0, s.setpoint_level};
			REG_PROP_GAIN:      return {16'd0, s.prop_gain};
			REG_DERIV_GAIN:     return {16'd0, s.deriv_gain};
			REG_TORQUE_BASE:    return {22'd0, s.torque_base};
			REG_TORQUE_GAIN:    return {16'd0, s.torque_gain};
			REG_LATERAL_GAIN:   return {16'd0, s.lateral_gain};
			default:            return {22'd0, s.torque_limit};
		endcase
	endfunction

	function automatic void store_register(input logic [REG_IDX_W-1:0] idx,
			input logic [31:0] data);
		case (idx)
			REG_SETPOINT_ANGLE: ctrl_cfg.setpoint_angle = data[14:0];
			REG_SETPOINT_LEVEL: ctrl_cfg.setpoint_level = data[15:0];
			REG_PROP_GAIN:      ctrl_cfg.prop_gain      = data[15:0];
			REG_DERIV_GAIN:     ctrl_cfg.deriv_gain     = data[15:0];
			REG_TORQUE_BASE:    ctrl_cfg.torque_base    = data[9:0];
			REG_TORQUE_GAIN:    ctrl_cfg.torque_gain    = data[15:0];
			REG_LATERAL_GAIN:   ctrl_cfg.lateral_gain   = data[15:0];
			default:            ctrl_cfg.torque_limit   = data[9:0];
		endcase
	endfunction

	// Series cosine over the folded phase, rounded to Q2.14.
	function automatic longint cosine_q14(input int step);
		longint phase;
		longint sq;
		longint acc;
		bit     flip;
		int     divs[4];
		divs  = '{56, 30, 12, 2};
		phase = (longint'(step) * Q28_TWO_PI) / COS_DEPTH;
		flip  = 1'b0;
		if (phase > Q28_HALF_PI) begin
			phase = Q28_PI - phase;
			flip  = 1'b1;
		end
		if (phase < 0)
			phase = 0;
		sq  = (phase * phase) >>> 28;
		acc = Q28_ONE - sq / 90;
		foreach (divs[k]) begin
			acc = Q28_ONE - ((sq * acc) >>> 28) / divs[k];
			if (acc < 0)
				acc = 0;
		end
		acc = (acc + 8192) >>> 14;
		return flip ? -acc : acc;
	endfunction

	function automatic out_beat_t predict_torque_offset(input logic [14:0] tilt);
		int        diff;
		int        err;
		int        mag;
		int        step;
		longint    level;
		longint    pd;
		longint    tq;
		longint    tmag;
		longint    trq;
		longint    omag;
		bit        neg_off;
		out_beat_t r;
		diff = int'(ctrl_cfg.setpoint_angle) - int'(tilt);
		diff = ((diff % TURN_UNITS) + TURN_UNITS) % TURN_UNITS;
		err  = (diff >= HALF_TURN_UNITS) ? diff - TURN_UNITS : diff;
		mag  = (err < 0) ? -err : err;
		step = (mag * COS_DEPTH + HALF_TURN_UNITS) / TURN_UNITS;
		if (2 * step > COS_DEPTH)
			step = COS_DEPTH - step;
		level = longint'(ctrl_cfg.setpoint_level) - cosine_q14(step);
		pd = longint'(ctrl_cfg.prop_gain) * level
			+ longint'(ctrl_cfg.deriv_gain) * (level - longint'(last_level));
		last_level = level[17:0];

		tq   = longint'(ctrl_cfg.torque_base) * (longint'(1) << 30)
			+ pd * longint'(ctrl_cfg.torque_gain);
		tmag = (tq < 0) ? -tq : tq;
		trq  = (tmag + (longint'(1) << 29)) >>> 30;
		r.saturated = 1'b0;
		if (trq > longint'(ctrl_cfg.torque_limit)) begin
			trq = longint'(ctrl_cfg.torque_limit);
			r.saturated = 1'b1;
		end
		r.torque = trq[9:0];

		omag = (longint'(ctrl_cfg.lateral_gain) * ((level < 0) ? -level : level) + 32768)
			>>> 16;
		// The offset opposes the level, mirrored when the tilt is past the setpoint.
		neg_off = (level > 0);
		if (err < 0)
			neg_off = !neg_off;
		if (neg_off) begin
			if (omag > 32768) begin
				omag = 32768;
				r.saturated = 1'b1;
			end
			r.lateral_offset = 16'(-omag);
		end else begin
			if (omag > 32767) begin
				omag = 32767;
				r.saturated = 1'b1;
			end
			r.lateral_offset = 16'(omag);
		end
		return r;
	endfunction

	// Each result beat is checked against the oldest prediction.
	always @(posedge clk) begin : check_results
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t unexpected result beat: torque %0d offset %0d saturated %0b",
					$time, torque, lateral_offset, saturated);
				fail_count++;
			end else begin
				want = expected_beats.pop_front();
				if (torque !== want.torque) begin
					$display("%0t torque: expected %0d, actual %0d", $time, want.torque, torque);
					fail_count++;
				end
				if (lateral_offset !== want.lateral_offset) begin
					$display("%0t lateral_offset: expected %0d, actual %0d", $time,
						want.lateral_offset, lateral_offset);
					fail_count++;
				end
				if (saturated !== want.saturated) begin
					$display("%0t saturated: expected %0b, actual %0b", $time,
						want.saturated, saturated);
					fail_count++;
				end
			end
		end
	end

	// Receiver stalls come in bursts; with idling off it always takes the beat.
	always @(negedge clk) begin
		if (!receiver_idles) begin
			out_ready = 1'b1;
			ready_burst = 0;
		end else if (ready_burst == 0) begin
			out_ready = ($urandom_range(0, 2) != 0);
			ready_burst = $urandom_range(1, 16);
		end else begin
			ready_burst--;
		end
	end

	task automatic send_tilt(input logic [14:0] v);
		int gap;
		@(negedge clk);
		if (sender_idles && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		tilt_sample = v;
		do @(posedge clk); while (!in_ready);
		expected_beats.push_back(predict_torque_offset(v));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		store_register(idx, data);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
		logic [31:0] mask;
		logic [31:0] got;
		mask = (32'd1 << reg_width(idx)) - 1;
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b0;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata & mask;
		if (got !== field_of(ctrl_cfg, idx)) begin
			$display("%0t register %0d readback: expected %0h, actual %0h", $time, idx,
				field_of(ctrl_cfg, idx), got);
			fail_count++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Writes every register with random bits above the field, then reads them all back.
	task automatic load_settings(input cfg_t s);
		logic [REG_IDX_W-1:0] idx;
		logic [31:0]          mask;
		logic [31:0]          junk;
		wait_drain();
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = REG_IDX_W'(i);
			mask = (32'd1 << reg_width(idx)) - 1;
			junk = $urandom;
			write_reg(idx, (junk & ~mask) | field_of(s, idx));
		end
		for (int i = 0; i < NUM_REGS; i++)
			check_reg(REG_IDX_W'(i));
	endtask

	function automatic logic [15:0] pick_field(input int width);
		logic [15:0] ones;
		ones = 16'((32'd1 << width) - 1);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ones;
			2: return 16'(32'd1 << (width - 1));
			3: return 16'((32'd1 << (width - 1)) - 1);
			default: return 16'($urandom) & ones;
		endcase
	endfunction

	function automatic cfg_t random_settings();
		cfg_t s;
		s.setpoint_angle = 15'(pick_field(15));
		s.setpoint_level = pick_field(16);
		s.prop_gain      = pick_field(16);
		s.deriv_gain     = pick_field(16);
		s.torque_base    = 10'(pick_field(10));
		s.torque_gain    = pick_field(16);
		s.lateral_gain   = pick_field(16);
		s.torque_limit   = 10'(pick_field(10));
		return s;
	endfunction

	// Mostly tilts that hover near the setpoint or drift slowly, some anywhere.
	function automatic logic [14:0] next_tilt();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: last_tilt = 15'(ctrl_cfg.setpoint_angle + $urandom_range(0, 1024) - 512);
			4, 5, 6:    last_tilt = 15'(last_tilt + $urandom_range(0, 64) - 32);
			7, 8:       last_tilt = 15'($urandom_range(0, TURN_UNITS - 1));
			default:    last_tilt = 15'($urandom_range(0, 32767));
		endcase
		return last_tilt;
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_tilt(next_tilt());
	endtask

	task automatic test_register_defaults();
		for (int i = 0; i < NUM_REGS; i++)
			check_reg(REG_IDX_W'(i));
	endtask

	task automatic test_directed_angles();
		logic [14:0] angles[14];
		angles = '{15'd11808, 15'd11808, 15'd11807, 15'd11809, 15'd288, 15'd287, 15'd23328,
			15'd0, 15'd23039, 15'h7FFF, 15'h4000, 15'h5555, 15'h2AAA, 15'd1};
		foreach (angles[k])
			send_tilt(angles[k]);
	endtask

	task automatic test_saturation_limits();
		cfg_t s;
		// Every gain at full scale with a zero torque limit and the lowest level.
		s.setpoint_angle = 15'd0;
		s.setpoint_level = 16'h8000;
		s.prop_gain      = 16'hFFFF;
		s.deriv_gain     = 16'hFFFF;
		s.torque_base    = 10'h3FF;
		s.torque_gain    = 16'hFFFF;
		s.lateral_gain   = 16'hFFFF;
		s.torque_limit   = 10'd0;
		load_settings(s);
		send_tilt(15'd0);
		send_tilt(15'd11520);
		send_tilt(15'd1);
		send_tilt(15'd23039);
		// Zero gains: nothing but rounding, with the setpoint beyond one turn.
		s.setpoint_angle = 15'h7FFF;
		s.setpoint_level = 16'h7FFF;
		s.prop_gain      = 16'd0;
		s.deriv_gain     = 16'd0;
		s.torque_base    = 10'd0;
		s.torque_gain    = 16'd0;
		s.lateral_gain   = 16'd0;
		s.torque_limit   = 10'h3FF;
		load_settings(s);
		send_tilt(15'h7FFF);
		send_tilt(15'd0);
		send_tilt(15'd9727);
		// Highest level with a quarter-turn setpoint drives the offset into its bound.
		s.setpoint_angle = 15'd5760;
		s.prop_gain      = 16'hFFFF;
		s.torque_gain    = 16'hFFFF;
		s.lateral_gain   = 16'hFFFF;
		load_settings(s);
		send_tilt(15'd5760);
		send_tilt(15'd17280);
		send_tilt(15'd0);
		send_tilt(15'd11520);
	endtask

	task automatic test_settings_sweep();
		for (int i = 0; i < 8; i++) begin
			load_settings(random_settings());
			send_random(60);
		end
	endtask

	task automatic test_drain_pause();
		load_settings(default_settings());
		send_random(20);
		wait_drain();
		send_random(20);
	endtask

	task automatic test_random_angles();
		send_random(400);
	endtask

	task automatic test_full_rate();
		wait_drain();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		send_random(150);
	endtask

	initial begin
		ctrl_cfg = default_settings();
		last_level = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_defaults();
		test_directed_angles();
		test_saturation_limits();
		test_settings_sweep();
		test_drain_pause();
		test_random_angles();
		test_full_rate();

		wait_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_beats.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/tpdc_pkg.sv
src/tpdc_regs.sv
src/tpdc_mac.sv
src/tpdc_cos_rom.sv
src/tilt_pd_torque_controller_unit.sv
src/tpdc_checker.sv
dv/tilt_pd_torque_controller_unit_tb.sv
